### design/assert_macros.svh
// Assertion macros included by rect_region_store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RRS_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rect_region_store check failed");

// Consequent that must hold in the cycle after the antecedent.
`define RRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rect_region_store sequence check failed");

`endif

### design/rrs_pkg.sv
// Shared types and constants of the rectangle region store.
package rrs_pkg;

    typedef enum logic [3:0] {
        OP_INCLUDE  = 4'd0,
        OP_EXCLUDE  = 4'd1,
        OP_CLIP     = 4'd2,
        OP_MOVE     = 4'd3,
        OP_CLEAR    = 4'd4,
        OP_POINT    = 4'd5,
        OP_BOUNDS   = 4'd6,
        OP_COUNT    = 4'd7,
        OP_READ     = 4'd8,
        OP_OPTIMIZE = 4'd9
    } op_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_RANGE    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_EX,
        S_CUT_CL,
        S_CUT_PC,
        S_INS_HEAD,
        S_INS_RD,
        S_INS_WR,
        S_READ_RD,
        S_READ_EX,
        S_OPT_A,
        S_OPT_P,
        S_OPT_RD,
        S_OPT_EX,
        S_RESP
    } state_t;

endpackage

### design/rrs_if.sv
// Request and response channel interfaces of the rectangle region store.
interface rrs_req_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic [3:0]                    op;
    logic signed [COORD_WIDTH-1:0] rect_left;
    logic signed [COORD_WIDTH-1:0] rect_top;
    logic signed [COORD_WIDTH-1:0] rect_right;
    logic signed [COORD_WIDTH-1:0] rect_bottom;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] shift_dx;
    logic signed [COORD_WIDTH-1:0] shift_dy;
    logic [5:0]                    entry_index;

    modport source (
        output valid, op, rect_left, rect_top, rect_right, rect_bottom,
               point_x, point_y, shift_dx, shift_dy, entry_index,
        input  ready
    );
    modport sink (
        input  valid, op, rect_left, rect_top, rect_right, rect_bottom,
               point_x, point_y, shift_dx, shift_dy, entry_index,
        output ready
    );
endinterface

interface rrs_rsp_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic                          hit;
    logic [6:0]                    rect_count;
    logic signed [COORD_WIDTH-1:0] out_left;
    logic signed [COORD_WIDTH-1:0] out_top;
    logic signed [COORD_WIDTH-1:0] out_right;
    logic signed [COORD_WIDTH-1:0] out_bottom;

    modport source (
        output valid, status, hit, rect_count, out_left, out_top, out_right, out_bottom,
        input  ready
    );
    modport sink (
        input  valid, status, hit, rect_count, out_left, out_top, out_right, out_bottom,
        output ready
    );
endinterface

### design/rect_region_store.sv
// Rectangle region store: list of rectangles in two banked memories, one op per word.
// Count, clear and unused ops go straight to the response; read fetches one entry; point test,
// bounds, move and clip walk every stored rectangle; exclude walks them and writes the kept
// rectangles and pieces to the other bank; include adds a copy of the list behind the new entry;
// optimize is quadratic in the count per pass. One word is in flight; a new one is taken in idle.
// Reset empties the region at once; memory contents are not cleared.
module rect_region_store
    import rrs_pkg::*;
#(
    parameter int MAX_RECTS   = 64,
    parameter int COORD_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    rrs_req_if.sink     req,
    rrs_rsp_if.source   rsp
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_RECTS);
    localparam int CNTW = $clog2(MAX_RECTS + 1);
    localparam int IW   = (CNTW > 6) ? CNTW : 6;

    typedef struct packed {
        logic signed [CW-1:0] l;
        logic signed [CW-1:0] t;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] b;
    } rect_t;

    function automatic logic is_empty(rect_t a);
        is_empty = (a.l >= a.r) || (a.t >= a.b);
    endfunction

    function automatic logic holds(rect_t o, rect_t i);
        holds = (o.l <= i.l) && (i.r <= o.r) && (o.t <= i.t) && (i.b <= o.b);
    endfunction

    function automatic logic meets(rect_t a, rect_t c);
        meets = (a.l < c.r) && (c.l < a.r) && (a.t < c.b) && (c.t < a.b);
    endfunction

    function automatic logic signed [CW-1:0] sat_add(logic signed [CW-1:0] v,
                                                     logic signed [CW-1:0] d);
        logic signed [CW:0] s;
        s = {v[CW-1], v} + {d[CW-1], d};
        if (s[CW] != s[CW-1])
            sat_add = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else
            sat_add = s[CW-1:0];
    endfunction

    // Registers
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    rect_t                c_reg, c_next;
    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [CW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 bank_reg, bank_next;
    logic [CNTW-1:0]      j_reg, j_next, n_reg, n_next, a_reg, a_next;
    rect_t                e_reg, e_next, p_reg, p_next, res_reg, res_next;
    logic [3:0]           pm_reg, pm_next;
    logic                 ovf_reg, ovf_next, rng_reg, rng_next, hit_reg, hit_next;
    logic                 found_reg, found_next;
    logic                 vert_reg, vert_next, any_reg, any_next, again_reg, again_next;
    logic                 ovalid_reg, ovalid_next;
    logic [1:0]           ostatus_reg, ostatus_next;
    logic                 ohit_reg, ohit_next;
    logic [6:0]           ocount_reg, ocount_next;
    rect_t                ores_reg, ores_next;

    // Memories
    logic [$bits(rect_t)-1:0] mem0 [MAX_RECTS];
    logic [$bits(rect_t)-1:0] mem1 [MAX_RECTS];
    logic [$bits(rect_t)-1:0] rd0, rd1;
    logic                     we, wother;
    logic [AW-1:0]            waddr, raddr;
    rect_t                    wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we && ((bank_reg ^ wother) == 1'b0))
            mem0[waddr] <= wdata;
        rd0 <= mem0[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we && ((bank_reg ^ wother) == 1'b1))
            mem1[waddr] <= wdata;
        rd1 <= mem1[raddr];
    end

    assign rdata = rect_t'(bank_reg ? rd1 : rd0);

    // Cut pieces of e_reg around c_reg
    rect_t                pc [4];
    logic [3:0]           keep;
    logic signed [CW-1:0] ly, hy;
    logic [1:0]           pk;
    logic                 room;

    always_comb
    begin
        ly = (e_reg.t > c_reg.t) ? e_reg.t : c_reg.t;
        hy = (e_reg.b < c_reg.b) ? e_reg.b : c_reg.b;
        pc[0] = '{l: e_reg.l, t: e_reg.t, r: e_reg.r, b: c_reg.t};
        pc[1] = '{l: e_reg.l, t: ly,      r: c_reg.l, b: hy};
        pc[2] = '{l: c_reg.r, t: ly,      r: e_reg.r, b: hy};
        pc[3] = '{l: e_reg.l, t: c_reg.b, r: e_reg.r, b: e_reg.b};
        keep[0] = (c_reg.t > e_reg.t) && !is_empty(pc[0]) && !holds(c_reg, pc[0]);
        keep[1] = (c_reg.l > e_reg.l) && !is_empty(pc[1]) && !holds(c_reg, pc[1]);
        keep[2] = (c_reg.r < e_reg.r) && !is_empty(pc[2]) && !holds(c_reg, pc[2]);
        keep[3] = (c_reg.b < e_reg.b) && !is_empty(pc[3]) && !holds(c_reg, pc[3]);
        if (pm_reg[0])
            pk = 2'd0;
        else if (pm_reg[1])
            pk = 2'd1;
        else if (pm_reg[2])
            pk = 2'd2;
        else
            pk = 2'd3;
        room = ({1'b0, n_reg} + {1'b0, cnt_reg}) <
               ((CNTW+1)'(MAX_RECTS) + {1'b0, j_reg} + (CNTW+1)'(1));
    end

    // Walk datapath helpers
    rect_t clip_r, move_r, q;
    logic  opt_merge;
    rect_t opt_p;

    always_comb
    begin
        clip_r   = rdata;
        clip_r.l = (rdata.l < c_reg.l) ? c_reg.l : rdata.l;
        clip_r.r = (rdata.r > c_reg.r) ? c_reg.r : rdata.r;
        clip_r.t = (rdata.t < c_reg.t) ? c_reg.t : rdata.t;
        clip_r.b = (rdata.b > c_reg.b) ? c_reg.b : rdata.b;
        move_r.l = sat_add(rdata.l, dx_reg);
        move_r.r = sat_add(rdata.r, dx_reg);
        move_r.t = sat_add(rdata.t, dy_reg);
        move_r.b = sat_add(rdata.b, dy_reg);
        q         = rdata;
        opt_p     = p_reg;
        opt_merge = 1'b0;
        if (!vert_reg)
        begin
            if (p_reg.t == q.t && p_reg.b == q.b)
            begin
                if (p_reg.r == q.l)
                begin
                    opt_p.r   = q.r;
                    opt_merge = 1'b1;
                end
                else if (p_reg.l == q.r)
                begin
                    opt_p.l   = q.l;
                    opt_merge = 1'b1;
                end
            end
        end
        else
        begin
            if (p_reg.l == q.l && p_reg.r == q.r)
            begin
                if (p_reg.b == q.t)
                begin
                    opt_p.b   = q.b;
                    opt_merge = 1'b1;
                end
                else if (p_reg.t == q.b)
                begin
                    opt_p.t   = q.t;
                    opt_merge = 1'b1;
                end
            end
        end
    end

    rect_t c_in;
    assign c_in = '{l: req.rect_left, t: req.rect_top, r: req.rect_right, b: req.rect_bottom};

    logic walk_done, opt_pass_end, rsp_free, cut_op;
    assign walk_done    = (j_reg == cnt_reg);
    assign opt_pass_end = (a_reg >= cnt_reg);
    assign rsp_free     = !ovalid_reg || rsp.ready;
    assign cut_op       = (op_reg == OP_INCLUDE) || (op_reg == OP_EXCLUDE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (op_t'(req.op))
                        OP_INCLUDE, OP_EXCLUDE:
                            state_next = is_empty(c_in) ? S_RESP : S_WALK_RD;
                        OP_CLIP, OP_MOVE, OP_POINT, OP_BOUNDS:
                            state_next = S_WALK_RD;
                        OP_READ:
                            state_next = S_READ_RD;
                        OP_OPTIMIZE:
                            state_next = S_OPT_A;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_WALK_RD:
            begin
                if (!walk_done)
                    state_next = S_WALK_EX;
                else if (op_reg == OP_INCLUDE)
                    state_next = S_INS_HEAD;
                else
                    state_next = S_RESP;
            end
            S_WALK_EX:
                state_next = cut_op ? S_CUT_CL : S_WALK_RD;
            S_CUT_CL:
            begin
                if (holds(c_reg, e_reg) || !meets(c_reg, e_reg))
                    state_next = S_WALK_RD;
                else
                    state_next = S_CUT_PC;
            end
            S_CUT_PC:
            begin
                if (pm_reg == 4'd0)
                    state_next = S_WALK_RD;
            end
            S_INS_HEAD:
                state_next = (cnt_reg < CNTW'(MAX_RECTS)) ? S_INS_RD : S_RESP;
            S_INS_RD:
                state_next = walk_done ? S_RESP : S_INS_WR;
            S_INS_WR:
                state_next = S_INS_RD;
            S_READ_RD:
                state_next = (idx_reg < IW'(cnt_reg)) ? S_READ_EX : S_RESP;
            S_READ_EX:
                state_next = S_RESP;
            S_OPT_A:
            begin
                if (!opt_pass_end)
                    state_next = S_OPT_P;
                else if (!any_reg && vert_reg && !again_reg)
                    state_next = S_RESP;
            end
            S_OPT_P:
                state_next = S_OPT_RD;
            S_OPT_RD:
                state_next = walk_done ? S_OPT_A : S_OPT_EX;
            S_OPT_EX:
                state_next = S_OPT_RD;
            S_RESP:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        op_next     = op_reg;
        c_next      = c_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        bank_next   = bank_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        a_next      = a_reg;
        e_next      = e_reg;
        p_next      = p_reg;
        res_next    = res_reg;
        pm_next     = pm_reg;
        ovf_next    = ovf_reg;
        rng_next    = rng_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        vert_next   = vert_reg;
        any_next    = any_reg;
        again_next  = again_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        ostatus_next = ostatus_reg;
        ohit_next   = ohit_reg;
        ocount_next = ocount_reg;
        ores_next   = ores_reg;
        we          = 1'b0;
        wother      = 1'b0;
        waddr       = '0;
        wdata       = e_reg;
        raddr       = j_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = op_t'(req.op);
                    c_next     = c_in;
                    px_next    = req.point_x;
                    py_next    = req.point_y;
                    dx_next    = req.shift_dx;
                    dy_next    = req.shift_dy;
                    idx_next   = IW'(req.entry_index);
                    j_next     = '0;
                    n_next     = '0;
                    a_next     = '0;
                    res_next   = '0;
                    ovf_next   = 1'b0;
                    rng_next   = 1'b0;
                    hit_next   = 1'b0;
                    found_next = 1'b0;
                    vert_next  = 1'b0;
                    any_next   = 1'b0;
                    again_next = 1'b0;
                    if (op_t'(req.op) == OP_CLEAR)
                        cnt_next = '0;
                end
            end
            S_WALK_RD:
            begin
                if (walk_done)
                begin
                    if (cut_op)
                    begin
                        cnt_next  = n_reg;
                        bank_next = !bank_reg;
                        j_next    = '0;
                    end
                    else if (op_reg == OP_CLIP)
                        cnt_next = n_reg;
                end
            end
            S_WALK_EX:
            begin
                j_next = j_reg + 1'b1;
                case (op_reg)
                    OP_INCLUDE, OP_EXCLUDE:
                    begin
                        e_next = rdata;
                        j_next = j_reg;
                    end
                    OP_CLIP:
                    begin
                        if (!is_empty(clip_r))
                        begin
                            we     = 1'b1;
                            waddr  = n_reg[AW-1:0];
                            wdata  = clip_r;
                            n_next = n_reg + 1'b1;
                        end
                    end
                    OP_MOVE:
                    begin
                        we    = 1'b1;
                        waddr = j_reg[AW-1:0];
                        wdata = move_r;
                    end
                    OP_POINT:
                    begin
                        if (rdata.l <= px_reg && px_reg < rdata.r &&
                            rdata.t <= py_reg && py_reg < rdata.b)
                            hit_next = 1'b1;
                    end
                    OP_BOUNDS:
                    begin
                        found_next = 1'b1;
                        if (!found_reg)
                            res_next = rdata;
                        else
                        begin
                            res_next.l = (rdata.l < res_reg.l) ? rdata.l : res_reg.l;
                            res_next.t = (rdata.t < res_reg.t) ? rdata.t : res_reg.t;
                            res_next.r = (rdata.r > res_reg.r) ? rdata.r : res_reg.r;
                            res_next.b = (rdata.b > res_reg.b) ? rdata.b : res_reg.b;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CUT_CL:
            begin
                if (holds(c_reg, e_reg))
                    j_next = j_reg + 1'b1;
                else if (!meets(c_reg, e_reg))
                begin
                    we     = 1'b1;
                    wother = 1'b1;
                    waddr  = n_reg[AW-1:0];
                    wdata  = e_reg;
                    n_next = n_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
                else
                    pm_next = keep;
            end
            S_CUT_PC:
            begin
                if (pm_reg == 4'd0)
                    j_next = j_reg + 1'b1;
                else
                begin
                    pm_next[pk] = 1'b0;
                    if (room)
                    begin
                        we     = 1'b1;
                        wother = 1'b1;
                        waddr  = n_reg[AW-1:0];
                        wdata  = pc[pk];
                        n_next = n_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                end
            end
            S_INS_HEAD:
            begin
                if (cnt_reg < CNTW'(MAX_RECTS))
                begin
                    we     = 1'b1;
                    wother = 1'b1;
                    waddr  = '0;
                    wdata  = c_reg;
                end
                else
                    ovf_next = 1'b1;
            end
            S_INS_RD:
            begin
                if (walk_done)
                begin
                    bank_next = !bank_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            S_INS_WR:
            begin
                we     = 1'b1;
                wother = 1'b1;
                waddr  = AW'(j_reg + 1'b1);
                wdata  = rdata;
                j_next = j_reg + 1'b1;
            end
            S_READ_RD:
            begin
                raddr = idx_reg[AW-1:0];
                if (!(idx_reg < IW'(cnt_reg)))
                    rng_next = 1'b1;
            end
            S_READ_EX:
                res_next = rdata;
            S_OPT_A:
            begin
                raddr = a_reg[AW-1:0];
                if (opt_pass_end)
                begin
                    a_next   = '0;
                    any_next = 1'b0;
                    if (any_reg)
                        again_next = 1'b1;
                    else if (!vert_reg)
                        vert_next = 1'b1;
                    else if (again_reg)
                    begin
                        vert_next  = 1'b0;
                        again_next = 1'b0;
                    end
                end
            end
            S_OPT_P:
            begin
                p_next = rdata;
                j_next = a_reg + 1'b1;
                n_next = a_reg + 1'b1;
            end
            S_OPT_RD:
            begin
                if (walk_done)
                begin
                    we       = 1'b1;
                    waddr    = a_reg[AW-1:0];
                    wdata    = p_reg;
                    cnt_next = n_reg;
                    a_next   = a_reg + 1'b1;
                end
            end
            S_OPT_EX:
            begin
                j_next = j_reg + 1'b1;
                if (opt_merge)
                begin
                    p_next   = opt_p;
                    any_next = 1'b1;
                end
                else
                begin
                    we     = 1'b1;
                    waddr  = n_reg[AW-1:0];
                    wdata  = q;
                    n_next = n_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = ovf_reg ? STATUS_OVERFLOW :
                                   (rng_reg ? STATUS_RANGE : STATUS_OK);
                    ohit_next    = hit_reg;
                    ocount_next  = 7'(cnt_reg);
                    ores_next    = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            bank_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            bank_reg   <= bank_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        c_reg       <= c_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        n_reg       <= n_next;
        a_reg       <= a_next;
        e_reg       <= e_next;
        p_reg       <= p_next;
        res_reg     <= res_next;
        pm_reg      <= pm_next;
        ovf_reg     <= ovf_next;
        rng_reg     <= rng_next;
        hit_reg     <= hit_next;
        found_reg   <= found_next;
        vert_reg    <= vert_next;
        any_reg     <= any_next;
        again_reg   <= again_next;
        ostatus_reg <= ostatus_next;
        ohit_reg    <= ohit_next;
        ocount_reg  <= ocount_next;
        ores_reg    <= ores_next;
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.status     = ostatus_reg;
    assign rsp.hit        = ohit_reg;
    assign rsp.rect_count = ocount_reg;
    assign rsp.out_left   = ores_reg.l;
    assign rsp.out_top    = ores_reg.t;
    assign rsp.out_right  = ores_reg.r;
    assign rsp.out_bottom = ores_reg.b;

    `include "assert_macros.svh"

    `RRS_ASSERT(a_count_in_range, cnt_reg <= CNTW'(MAX_RECTS))
    `RRS_ASSERT(a_write_in_range, !(we && (state_reg == S_CUT_PC)) || (n_reg < CNTW'(MAX_RECTS)))
    `RRS_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg != S_IDLE)
    `RRS_ASSERT_NEXT(a_resp_loads, (state_reg == S_RESP) && rsp_free, rsp.valid)

endmodule

### tb/sv/tb_rect_region_store.sv
// Testbench for rect_region_store: random and directed region ops checked by a scoreboard.
module tb_rect_region_store
    import rrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 64;
    localparam int CMIN       = -32768;
    localparam int CMAX       = 32767;
    localparam int IDLE_LIMIT = 2000000;
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        int l, t, r, b;
    } box_t;

    typedef struct {
        logic [3:0] op;
        box_t       rc;
        int         px, py, dx, dy;
        logic [5:0] idx;
    } word_t;

    typedef struct {
        logic [1:0] status;
        logic       hit;
        logic [6:0] count;
        box_t       rc;
    } answer_t;

    class region_scoreboard;
        box_t    rects[$];
        answer_t pending[$];
        int      errors;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function bit is_empty(box_t a);
            return a.l >= a.r || a.t >= a.b;
        endfunction

        function bit holds(box_t o, box_t i);
            return o.l <= i.l && i.r <= o.r && o.t <= i.t && i.b <= o.b;
        endfunction

        function bit meets(box_t a, box_t c);
            return a.l < c.r && c.l < a.r && a.t < c.b && c.t < a.b;
        endfunction

        function int sat(int v);
            return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
        endfunction

        function bit cut_out(box_t c);
            box_t kept[$];
            box_t e;
            box_t pc[$];
            box_t p;
            int   rem, ly, hy;
            bit   ovf;
            ovf = 0;
            for (int j = 0; j < rects.size(); j++)
            begin
                e   = rects[j];
                rem = rects.size() - j - 1;
                if (holds(c, e))
                    continue;
                if (!meets(c, e))
                begin
                    kept.push_back(e);
                    continue;
                end
                ly = e.t > c.t ? e.t : c.t;
                hy = e.b < c.b ? e.b : c.b;
                pc.delete();
                if (c.t > e.t) pc.push_back('{e.l, e.t, e.r, c.t});
                if (c.l > e.l) pc.push_back('{e.l, ly, c.l, hy});
                if (c.r < e.r) pc.push_back('{c.r, ly, e.r, hy});
                if (c.b < e.b) pc.push_back('{e.l, c.b, e.r, e.b});
                foreach (pc[k])
                begin
                    p = pc[k];
                    if (is_empty(p) || holds(c, p))
                        continue;
                    if (kept.size() + rem < CAPACITY)
                        kept.push_back(p);
                    else
                        ovf = 1;
                end
            end
            rects = kept;
            return ovf;
        endfunction

        function bit merge_sweep(bit vertical);
            bit any, d;
            int o;
            any = 0;
            for (int a = 0; a < rects.size(); a++)
            begin
                o = a + 1;
                while (o < rects.size())
                begin
                    d = 0;
                    if (!vertical)
                    begin
                        if (rects[a].t == rects[o].t && rects[a].b == rects[o].b)
                        begin
                            if (rects[a].r == rects[o].l)
                            begin
                                rects[a].r = rects[o].r;
                                d = 1;
                            end
                            else if (rects[a].l == rects[o].r)
                            begin
                                rects[a].l = rects[o].l;
                                d = 1;
                            end
                        end
                    end
                    else if (rects[a].l == rects[o].l && rects[a].r == rects[o].r)
                    begin
                        if (rects[a].b == rects[o].t)
                        begin
                            rects[a].b = rects[o].b;
                            d = 1;
                        end
                        else if (rects[a].t == rects[o].b)
                        begin
                            rects[a].t = rects[o].t;
                            d = 1;
                        end
                    end
                    if (d)
                    begin
                        rects.delete(o);
                        any = 1;
                    end
                    else
                        o++;
                end
            end
            return any;
        endfunction

        function void note(word_t w);
            answer_t ans;
            box_t    c;
            int      i;
            bit      again;
            ans = '{STATUS_OK, 1'b0, 7'd0, '{0, 0, 0, 0}};
            c   = w.rc;
            case (w.op)
                OP_INCLUDE:
                    if (!is_empty(c))
                    begin
                        if (cut_out(c))
                            ans.status = STATUS_OVERFLOW;
                        if (rects.size() < CAPACITY)
                            rects.push_front(c);
                        else
                            ans.status = STATUS_OVERFLOW;
                    end
                OP_EXCLUDE:
                    if (!is_empty(c) && cut_out(c))
                        ans.status = STATUS_OVERFLOW;
                OP_CLIP:
                begin
                    i = 0;
                    while (i < rects.size())
                    begin
                        if (rects[i].l < c.l) rects[i].l = c.l;
                        if (rects[i].r > c.r) rects[i].r = c.r;
                        if (rects[i].t < c.t) rects[i].t = c.t;
                        if (rects[i].b > c.b) rects[i].b = c.b;
                        if (is_empty(rects[i]))
                            rects.delete(i);
                        else
                            i++;
                    end
                end
                OP_MOVE:
                    foreach (rects[k])
                    begin
                        rects[k].l = sat(rects[k].l + w.dx);
                        rects[k].r = sat(rects[k].r + w.dx);
                        rects[k].t = sat(rects[k].t + w.dy);
                        rects[k].b = sat(rects[k].b + w.dy);
                    end
                OP_CLEAR:
                    rects.delete();
                OP_POINT:
                    foreach (rects[k])
                        if (rects[k].l <= w.px && w.px < rects[k].r &&
                            rects[k].t <= w.py && w.py < rects[k].b)
                            ans.hit = 1'b1;
                OP_BOUNDS:
                    if (rects.size() > 0)
                    begin
                        ans.rc = rects[0];
                        foreach (rects[k])
                        begin
                            if (rects[k].l < ans.rc.l) ans.rc.l = rects[k].l;
                            if (rects[k].t < ans.rc.t) ans.rc.t = rects[k].t;
                            if (rects[k].r > ans.rc.r) ans.rc.r = rects[k].r;
                            if (rects[k].b > ans.rc.b) ans.rc.b = rects[k].b;
                        end
                    end
                OP_READ:
                    if (w.idx < rects.size())
                        ans.rc = rects[w.idx];
                    else
                        ans.status = STATUS_RANGE;
                OP_OPTIMIZE:
                    do
                    begin
                        again = 0;
                        while (merge_sweep(1'b0)) again = 1;
                        while (merge_sweep(1'b1)) again = 1;
                    end
                    while (again);
                default: ;
            endcase
            ans.count = 7'(rects.size());
            pending.push_back(ans);
        endfunction

        task check(answer_t got);
            answer_t e;
            if (pending.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d exp %0d", got.status, e.status));
            if (got.hit !== e.hit)
                report($sformatf("hit %0d exp %0d", got.hit, e.hit));
            if (got.count !== e.count)
                report($sformatf("count %0d exp %0d", got.count, e.count));
            if (got.rc.l != e.rc.l || got.rc.t != e.rc.t ||
                got.rc.r != e.rc.r || got.rc.b != e.rc.b)
                report($sformatf("rect %0d,%0d,%0d,%0d exp %0d,%0d,%0d,%0d",
                    got.rc.l, got.rc.t, got.rc.r, got.rc.b,
                    e.rc.l, e.rc.t, e.rc.r, e.rc.b));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   idle_cycles;
    int   sent;
    region_scoreboard sb;

    rrs_req_if #(.COORD_WIDTH(16)) req_if ();
    rrs_rsp_if #(.COORD_WIDTH(16)) rsp_if ();

    rect_region_store #(.MAX_RECTS(CAPACITY), .COORD_WIDTH(16)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiver stalls, with long runs of no stall
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_mode   <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= $urandom_range(0, 3) != 0;
                default: rsp_if.ready <= $urandom_range(0, 9) == 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check('{rsp_if.status, rsp_if.hit, rsp_if.rect_count,
                '{int'(rsp_if.out_left), int'(rsp_if.out_top),
                  int'(rsp_if.out_right), int'(rsp_if.out_bottom)}});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_rect_region_store failed");
            $finish;
        end
    end

    task automatic send_word(word_t w);
        int g;
        req_if.valid       <= 1'b1;
        req_if.op          <= w.op;
        req_if.rect_left   <= w.rc.l[15:0];
        req_if.rect_top    <= w.rc.t[15:0];
        req_if.rect_right  <= w.rc.r[15:0];
        req_if.rect_bottom <= w.rc.b[15:0];
        req_if.point_x     <= w.px[15:0];
        req_if.point_y     <= w.py[15:0];
        req_if.shift_dx    <= w.dx[15:0];
        req_if.shift_dy    <= w.dy[15:0];
        req_if.entry_index <= w.idx;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note(w);
        sent++;
        g = gap_len();
        if (g > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (req_if.valid)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function int any_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 20) * 3 - 30;
        if (r < 95) return int'($signed(16'($urandom())));
        return r[0] ? CMIN : CMAX;
    endfunction

    function word_t rand_word();
        word_t w;
        int    r;
        r = $urandom_range(0, 99);
        w.rc.l = any_coord();
        w.rc.t = any_coord();
        w.rc.r = ($urandom_range(0, 9) == 0) ? any_coord() : w.rc.l + $urandom_range(1, 24);
        w.rc.b = ($urandom_range(0, 9) == 0) ? any_coord() : w.rc.t + $urandom_range(1, 24);
        w.rc.r = w.rc.r > CMAX ? CMAX : w.rc.r;
        w.rc.b = w.rc.b > CMAX ? CMAX : w.rc.b;
        w.px   = any_coord();
        w.py   = any_coord();
        w.dx   = ($urandom_range(0, 9) == 0) ? int'($signed(16'($urandom())))
                                              : $urandom_range(0, 12) - 6;
        w.dy   = ($urandom_range(0, 9) == 0) ? int'($signed(16'($urandom())))
                                              : $urandom_range(0, 12) - 6;
        w.idx  = ($urandom_range(0, 3) == 0) ? 6'($urandom())
                                              : 6'($urandom_range(0, sb.rects.size()));
        if (r < 30)      w.op = OP_INCLUDE;
        else if (r < 45) w.op = OP_EXCLUDE;
        else if (r < 49)
        begin
            w.op   = OP_CLIP;
            w.rc.l = w.rc.l - 30;
            w.rc.t = w.rc.t - 30;
            w.rc.r = w.rc.l + 80;
            w.rc.b = w.rc.t + 80;
            w.rc.l = w.rc.l < CMIN ? CMIN : w.rc.l;
            w.rc.t = w.rc.t < CMIN ? CMIN : w.rc.t;
            w.rc.r = w.rc.r > CMAX ? CMAX : w.rc.r;
            w.rc.b = w.rc.b > CMAX ? CMAX : w.rc.b;
        end
        else if (r < 54) w.op = OP_MOVE;
        else if (r < 56) w.op = OP_CLEAR;
        else if (r < 65) w.op = OP_POINT;
        else if (r < 71) w.op = OP_BOUNDS;
        else if (r < 75) w.op = OP_COUNT;
        else if (r < 88) w.op = OP_READ;
        else if (r < 96) w.op = OP_OPTIMIZE;
        else             w.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        return w;
    endfunction

    function word_t mk(logic [3:0] op, int l, int t, int r, int b);
        word_t w;
        w = '{op, '{l, t, r, b}, 0, 0, 0, 0, 6'd0};
        return w;
    endfunction

    initial
    begin
        word_t w;
        sb    = new();
        sent  = 0;
        rst_n = 1'b0;
        idle_cycles        = 0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_COUNT;
        req_if.rect_left   = '0;
        req_if.rect_top    = '0;
        req_if.rect_right  = '0;
        req_if.rect_bottom = '0;
        req_if.point_x     = '0;
        req_if.point_y     = '0;
        req_if.shift_dx    = '0;
        req_if.shift_dy    = '0;
        req_if.entry_index = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(mk(OP_BOUNDS, 0, 0, 0, 0));
        send_word(mk(OP_READ, 0, 0, 0, 0));
        send_word(mk(OP_INCLUDE, 5, 5, 5, 9));
        send_word(mk(OP_INCLUDE, CMIN, CMIN, CMAX, CMAX));
        w = mk(OP_POINT, 0, 0, 0, 0);
        w.px = CMIN;
        w.py = CMAX - 1;
        send_word(w);
        send_word(mk(OP_EXCLUDE, -10, -10, 10, 10));
        send_word(mk(OP_EXCLUDE, 3, 3, 1, 8));
        send_word(mk(OP_BOUNDS, 0, 0, 0, 0));
        w = mk(OP_READ, 0, 0, 0, 0);
        w.idx = 6'd3;
        send_word(w);
        w.idx = 6'd63;
        send_word(w);
        send_word(mk(OP_OPTIMIZE, 0, 0, 0, 0));
        w = mk(OP_MOVE, 0, 0, 0, 0);
        w.dx = CMAX;
        w.dy = CMIN;
        send_word(w);
        send_word(mk(OP_BOUNDS, 0, 0, 0, 0));
        send_word(mk(OP_CLIP, -100, -100, 100, 100));
        send_word(mk(OP_INCLUDE, 0, 0, 10, 10));
        send_word(mk(OP_CLIP, 5, 5, 5, 5));
        send_word(mk(OP_UNUSED_HI, 0, 0, 0, 0));
        send_word(mk(OP_UNUSED_LO, 0, 0, 0, 0));
        send_word(mk(OP_INCLUDE, 0, 0, 4, 4));
        send_word(mk(OP_CLEAR, 0, 0, 0, 0));
        send_word(mk(OP_COUNT, 0, 0, 0, 0));
        drain();

        while (sent < 850)
        begin
            if ($urandom_range(0, 299) == 0)
            begin
                // tile fill: runs past capacity, then merges back
                for (int k = 0; k < 70; k++)
                    send_word(mk(OP_INCLUDE, (k % 9) * 2, (k / 9) * 2,
                        (k % 9) * 2 + 1 + (k % 2), (k / 9) * 2 + 1));
                send_word(mk(OP_EXCLUDE, 2, 2, 9, 9));
                send_word(mk(OP_OPTIMIZE, 0, 0, 0, 0));
            end
            else
                send_word(rand_word());
            if ($urandom_range(0, 149) == 0)
                drain();
        end
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_rect_region_store passed");
        else
            $display("tb_rect_region_store failed");
        $finish;
    end
endmodule
